// ----- hdl/dde_pkg.sv -----
// Shared constants and types for the dynamic detail enhancer.
`default_nettype none

package dde_pkg;

  // Default geometry
  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int COEFF_FRAC_BITS_DEF = 24;

  // Amount and gain arithmetic, Q1.16 amount and Q0.16 gain
  localparam int          AMOUNT_BITS  = 17;
  localparam int          GAIN_BITS    = 15;
  localparam int          DETAIL_SHIFT = 16;
  localparam logic [16:0] AMOUNT_FULL  = 17'd65536;
  localparam logic [14:0] GAIN_BASE    = 15'd5243;
  localparam logic [14:0] GAIN_SPAN    = 15'd11796;

  // env / 0.32 in Q0.16 is env * 25 >> (SAMPLE_BITS - 14)
  localparam logic [4:0]  RATIO_MUL        = 5'd25;
  localparam int          RATIO_SHIFT_BASE = 14;

  // Register reset values; coefficients Q0.24, amount Q1.16
  localparam logic [16:0] AMOUNT_TARGET_RST = 17'd0;
  localparam logic [23:0] LOWPASS_RST       = 24'd5741700;
  localparam logic [23:0] SMOOTHING_RST     = 24'd11647;
  localparam logic [23:0] ATTACK_RST        = 24'd43635;
  localparam logic [23:0] RELEASE_RST       = 24'd2913;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_AMOUNT_TARGET   = 3'd0,
    REG_LOWPASS_COEFF   = 3'd1,
    REG_SMOOTHING_COEFF = 3'd2,
    REG_ATTACK_COEFF    = 3'd3,
    REG_RELEASE_COEFF   = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    STEP_AMOUNT = 4'd0,
    STEP_LOW_L  = 4'd1,
    STEP_LOW_R  = 4'd2,
    STEP_ENV    = 4'd3,
    STEP_RATIO  = 4'd4,
    STEP_GAIN   = 4'd5,
    STEP_DETAIL = 4'd6,
    STEP_OUT_L  = 4'd7,
    STEP_OUT_R  = 4'd8
  } step_e;

endpackage

`default_nettype wire

// ----- hdl/dde_ifs.sv -----
// Channel interfaces of the dynamic detail enhancer: sample input, sample output, config.
`default_nettype none

interface dde_in_if
  import dde_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          restart;

  modport source (output valid, left_in, right_in, restart, input ready);
  modport sink   (input valid, left_in, right_in, restart, output ready);
endinterface

interface dde_out_if
  import dde_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface dde_cfg_if
  import dde_pkg::*;
#(
  parameter int DATA_BITS = COEFF_FRAC_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/dynamic_detail_enhancer.sv -----
// Top level: level-dependent high-frequency detail lift for stereo samples.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------
//  cfg_i   | in  | valid / ready | index (3 b), data (max(COEFF_FRAC_BITS,17) b)
//  in_i    | in  | valid / ready | left_in, right_in (SAMPLE_BITS), restart
//  out_o   | out | valid / ready | left_out, right_out (SAMPLE_BITS)
//
// A normal item is accepted, then runs nine multiply/accumulate steps (ST_MUL, ST_ACC) through
// the single shared multiplier, then is handed over to the output register. A restart item
// goes straight to the hand-over. The output register lets the next item be accepted and
// worked on while a result waits; the hand-over state holds while that result is not taken.
// Reset (async, active low) restores the register defaults and clears the filter state.
// Config is always ready and is expected only while the block is idle.
`default_nettype none

module dynamic_detail_enhancer
  import dde_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dde_cfg_if.sink    cfg_i,
  dde_in_if.sink     in_i,
  dde_out_if.source  out_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int CF     = COEFF_FRAC_BITS;
  localparam int CFG_DW = (CF > AMOUNT_BITS) ? CF : AMOUNT_BITS;
  localparam int AW     = (SB + 1 > AMOUNT_BITS + 1) ? SB + 1 : AMOUNT_BITS + 1;
  localparam int BW     = CFG_DW + 1;
  localparam int PW     = AW + BW;
  localparam int RATIO_SHIFT = SB - RATIO_SHIFT_BASE;

  localparam logic signed [PW-1:0] HALF_F   = PW'(64'sd1 <<< (CF - 1));
  localparam logic signed [PW-1:0] HALF_16  = PW'(64'sd1 <<< (DETAIL_SHIFT - 1));
  localparam logic signed [PW-1:0] SAT_HI   = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_LO   = -SAT_HI - PW'(1);
  localparam logic signed [PW-1:0] FULL_P   = PW'($signed({1'b0, AMOUNT_FULL}));
  localparam logic signed [PW-1:0] G_BASE_P = PW'($signed({1'b0, GAIN_BASE}));

  // Configuration registers
  logic [AMOUNT_BITS-1:0] amount_target_q;
  logic [CF-1:0]          lowpass_q, smoothing_q, attack_q, release_q;

  // Filter state
  logic [AMOUNT_BITS-1:0] amount_now_q, amount_now_d;
  logic signed [SB-1:0]   low_l_q, low_l_d, low_r_q, low_r_d;
  logic [SB-1:0]          env_q, env_d;

  // Per-item working registers
  logic signed [SB-1:0]   x_l_q, x_r_q;
  logic [SB-1:0]          level_q;
  logic [AMOUNT_BITS-1:0] quiet_q, quiet_d;
  logic [GAIN_BITS-1:0]   gain_q, gain_d;
  logic [GAIN_BITS-1:0]   detail_q, detail_d;
  logic signed [SB-1:0]   res_l_q, res_l_d, res_r_q, res_r_d;

  // Output register
  logic                   out_valid_q;
  logic signed [SB-1:0]   out_l_q, out_r_q;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  logic                   in_take, out_load;
  logic [SB-1:0]          abs_l, abs_r, level_in;
  logic [SB:0]            level_sum;

  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   prod;

  logic signed [AMOUNT_BITS:0] amt_diff;
  logic signed [SB:0]     diff_l, diff_r, env_diff;
  logic signed [PW-1:0]   rnd_f, rnd_16, ratio_raw, acc_sum, out_sum;
  logic signed [SB-1:0]   x_sel, sat_val;
  logic [AMOUNT_BITS-1:0] ratio;

  // Config port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_target_q <= AMOUNT_TARGET_RST;
      lowpass_q       <= CF'(LOWPASS_RST);
      smoothing_q     <= CF'(SMOOTHING_RST);
      attack_q        <= CF'(ATTACK_RST);
      release_q       <= CF'(RELEASE_RST);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_AMOUNT_TARGET: begin
          amount_target_q <= (cfg_i.data[AMOUNT_BITS-1:0] > AMOUNT_FULL) ?
                             AMOUNT_FULL : cfg_i.data[AMOUNT_BITS-1:0];
        end
        REG_LOWPASS_COEFF:   lowpass_q   <= cfg_i.data[CF-1:0];
        REG_SMOOTHING_COEFF: smoothing_q <= cfg_i.data[CF-1:0];
        REG_ATTACK_COEFF:    attack_q    <= cfg_i.data[CF-1:0];
        REG_RELEASE_COEFF:   release_q   <= cfg_i.data[CF-1:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_take    = in_i.valid && in_i.ready;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // Mean absolute level; full-scale negative keeps its magnitude
  assign abs_l     = in_i.left_in[SB-1]  ? SB'(-in_i.left_in)  : SB'(in_i.left_in);
  assign abs_r     = in_i.right_in[SB-1] ? SB'(-in_i.right_in) : SB'(in_i.right_in);
  assign level_sum = {1'b0, abs_l} + {1'b0, abs_r} + (SB+1)'(1);
  assign level_in  = level_sum[SB:1];

  // Operand differences
  assign amt_diff = $signed({1'b0, amount_target_q}) - $signed({1'b0, amount_now_q});
  assign diff_l   = (SB+1)'(x_l_q) - (SB+1)'(low_l_q);
  assign diff_r   = (SB+1)'(x_r_q) - (SB+1)'(low_r_q);
  assign env_diff = $signed({1'b0, level_q}) - $signed({1'b0, env_q});

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      STEP_AMOUNT: begin
        mul_a = AW'(amt_diff);
        mul_b = BW'($signed({1'b0, smoothing_q}));
      end
      STEP_LOW_L, STEP_OUT_L: begin
        mul_a = AW'(diff_l);
        mul_b = (step_q == STEP_LOW_L) ? BW'($signed({1'b0, lowpass_q})) :
                                         BW'($signed({1'b0, detail_q}));
      end
      STEP_LOW_R, STEP_OUT_R: begin
        mul_a = AW'(diff_r);
        mul_b = (step_q == STEP_LOW_R) ? BW'($signed({1'b0, lowpass_q})) :
                                         BW'($signed({1'b0, detail_q}));
      end
      STEP_ENV: begin
        mul_a = AW'(env_diff);
        mul_b = (level_q > env_q) ? BW'($signed({1'b0, attack_q})) :
                                    BW'($signed({1'b0, release_q}));
      end
      STEP_RATIO: begin
        mul_a = AW'($signed({1'b0, env_q}));
        mul_b = BW'($signed({1'b0, RATIO_MUL}));
      end
      STEP_GAIN: begin
        mul_a = AW'($signed({1'b0, quiet_q}));
        mul_b = BW'($signed({1'b0, GAIN_SPAN}));
      end
      STEP_DETAIL: begin
        mul_a = AW'($signed({1'b0, amount_now_q}));
        mul_b = BW'($signed({1'b0, gain_q}));
      end
      default: ;
    endcase
  end

  dde_mul_unit #(
    .A_BITS(AW),
    .B_BITS(BW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (state_q == ST_MUL),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Round half up, then apply the product to the current step's target
  assign rnd_f     = (prod + HALF_F) >>> CF;
  assign rnd_16    = (prod + HALF_16) >>> DETAIL_SHIFT;
  assign ratio_raw = prod >>> RATIO_SHIFT;
  assign ratio     = (ratio_raw > FULL_P) ? AMOUNT_FULL : ratio_raw[AMOUNT_BITS-1:0];

  assign x_sel   = (step_q == STEP_OUT_L) ? x_l_q : x_r_q;
  assign out_sum = PW'(x_sel) + rnd_16;
  assign sat_val = (out_sum > SAT_HI) ? SAT_HI[SB-1:0] :
                   (out_sum < SAT_LO) ? SAT_LO[SB-1:0] : out_sum[SB-1:0];

  always_comb begin
    amount_now_d = amount_now_q;
    low_l_d      = low_l_q;
    low_r_d      = low_r_q;
    env_d        = env_q;
    quiet_d      = quiet_q;
    gain_d       = gain_q;
    detail_d     = detail_q;
    res_l_d      = res_l_q;
    res_r_d      = res_r_q;
    acc_sum      = '0;
    if (in_take && in_i.restart) begin
      amount_now_d = amount_target_q;
      low_l_d      = '0;
      low_r_d      = '0;
      env_d        = '0;
      res_l_d      = in_i.left_in;
      res_r_d      = in_i.right_in;
    end else if (state_q == ST_ACC) begin
      case (step_q)
        STEP_AMOUNT: begin
          acc_sum      = PW'($signed({1'b0, amount_now_q})) + rnd_f;
          amount_now_d = acc_sum[AMOUNT_BITS-1:0];
        end
        STEP_LOW_L: begin
          acc_sum = PW'(low_l_q) + rnd_f;
          low_l_d = acc_sum[SB-1:0];
        end
        STEP_LOW_R: begin
          acc_sum = PW'(low_r_q) + rnd_f;
          low_r_d = acc_sum[SB-1:0];
        end
        STEP_ENV: begin
          acc_sum = PW'($signed({1'b0, env_q})) + rnd_f;
          env_d   = acc_sum[SB-1:0];
        end
        STEP_RATIO:  quiet_d = AMOUNT_FULL - ratio;
        STEP_GAIN: begin
          acc_sum = G_BASE_P + rnd_16;
          gain_d  = acc_sum[GAIN_BITS-1:0];
        end
        STEP_DETAIL: detail_d = rnd_16[GAIN_BITS-1:0];
        STEP_OUT_L:  res_l_d  = sat_val;
        STEP_OUT_R:  res_r_d  = sat_val;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = in_i.restart ? ST_DONE : ST_MUL;
          step_d  = STEP_AMOUNT;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (step_q == STEP_OUT_R) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_MUL;
          step_d  = step_e'(step_q + 4'd1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= STEP_AMOUNT;
      out_valid_q  <= 1'b0;
      amount_now_q <= AMOUNT_TARGET_RST;
      low_l_q      <= '0;
      low_r_q      <= '0;
      env_q        <= '0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      amount_now_q <= amount_now_d;
      low_l_q      <= low_l_d;
      low_r_q      <= low_r_d;
      env_q        <= env_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_l_q   <= in_i.left_in;
      x_r_q   <= in_i.right_in;
      level_q <= level_in;
    end
    quiet_q  <= quiet_d;
    gain_q   <= gain_d;
    detail_q <= detail_d;
    res_l_q  <= res_l_d;
    res_r_q  <= res_r_d;
    if (out_load) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

  // Assertions
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !in_i.ready)
    else $error("input taken while an item is in progress");

  a_amount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    amount_now_q <= AMOUNT_FULL)
    else $error("smoothed amount above full scale");

  a_quiet_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && step_q == STEP_GAIN) |-> quiet_q <= AMOUNT_FULL)
    else $error("quietness above full scale");

  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_o.ready) |=> state_q == ST_DONE)
    else $error("pending result overwritten");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(out_l_q) && $stable(out_r_q))
    else $error("output register changed while stalled");

endmodule

`default_nettype wire

// ----- hdl/dde_mul_unit.sv -----
// Shared signed multiplier with registered product.
`default_nettype none

module dde_mul_unit #(
  parameter int A_BITS = 25,
  parameter int B_BITS = 25
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [A_BITS-1:0]        a_i,
  input  wire logic signed [B_BITS-1:0]        b_i,
  output      logic signed [A_BITS+B_BITS-1:0] p_o
);

  logic signed [A_BITS+B_BITS-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (A_BITS+B_BITS)'(a_i) * (A_BITS+B_BITS)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
